FILE: hdl/hmf_pkg.sv
// ----------------------------------------------------------------------------
// HTTP message framer package
// Shared types, character codes, part codes and name tables.
// ----------------------------------------------------------------------------
package hmf_pkg;

	localparam int LENGTH_BITS_DEFAULT = 32;

	localparam logic [4:0] CL_LEN  = 5'd14;
	localparam logic [4:0] TE_LEN  = 5'd17;
	localparam logic [4:0] COL_MAX = 5'd31;

	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_TAB    = 8'h09;
	localparam logic [7:0] CHAR_VT     = 8'h0B;
	localparam logic [7:0] CHAR_FF     = 8'h0C;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_COLON  = 8'h3A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam logic [2:0] CODE_HEADER = 3'd0;
	localparam logic [2:0] CODE_BODY   = 3'd1;
	localparam logic [2:0] CODE_SIZE   = 3'd2;
	localparam logic [2:0] CODE_DATA   = 3'd3;
	localparam logic [2:0] CODE_CRLF   = 3'd4;

	typedef enum logic [4:0] {
		MODE_HEADER = 5'b00001,
		MODE_BODY   = 5'b00010,
		MODE_SIZE   = 5'b00100,
		MODE_DATA   = 5'b01000,
		MODE_CRLF   = 5'b10000
	} mode_t;

	typedef enum logic [3:0] {
		PH_NAME   = 4'b0001,
		PH_BLANKS = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_REST   = 4'b1000
	} phase_t;

	typedef struct packed {
		mode_t       mode;
		logic [4:0]  col;
		logic        saw_cr;
		logic        len_match;
		logic        enc_match;
		phase_t      phase;
		logic        chunked;
	} ctl_t;

	localparam ctl_t CTL_RESET = '{
		mode: MODE_HEADER, col: 5'd0, saw_cr: 1'b0, len_match: 1'b1,
		enc_match: 1'b1, phase: PH_NAME, chunked: 1'b0
	};

	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		unique case (m)
			MODE_BODY: c = CODE_BODY;
			MODE_SIZE: c = CODE_SIZE;
			MODE_DATA: c = CODE_DATA;
			MODE_CRLF: c = CODE_CRLF;
			default:   c = CODE_HEADER;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] cl_char(input logic [4:0] idx);
		logic [7:0] c;
		unique case (idx)
			5'd0:    c = "c";
			5'd1:    c = "o";
			5'd2:    c = "n";
			5'd3:    c = "t";
			5'd4:    c = "e";
			5'd5:    c = "n";
			5'd6:    c = "t";
			5'd7:    c = "-";
			5'd8:    c = "l";
			5'd9:    c = "e";
			5'd10:   c = "n";
			5'd11:   c = "g";
			5'd12:   c = "t";
			5'd13:   c = "h";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] te_char(input logic [4:0] idx);
		logic [7:0] c;
		unique case (idx)
			5'd0:    c = "t";
			5'd1:    c = "r";
			5'd2:    c = "a";
			5'd3:    c = "n";
			5'd4:    c = "s";
			5'd5:    c = "f";
			5'd6:    c = "e";
			5'd7:    c = "r";
			5'd8:    c = "-";
			5'd9:    c = "e";
			5'd10:   c = "n";
			5'd11:   c = "c";
			5'd12:   c = "o";
			5'd13:   c = "d";
			5'd14:   c = "i";
			5'd15:   c = "n";
			5'd16:   c = "g";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Bit 4 flags a hex digit; bits 3:0 hold its value.
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] h;
		if (b >= "0" && b <= "9") begin
			h = {1'b1, b[3:0]};
		end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
			h = {1'b1, b[3:0] + 4'd9};
		end else begin
			h = 5'd0;
		end
		return h;
	endfunction

endpackage

FILE: hdl/hmf_step.sv
// ----------------------------------------------------------------------------
// HTTP message framer byte step
// Next-state and tag logic for one byte of the message stream.
// ----------------------------------------------------------------------------
module hmf_step #(
	parameter int LENGTH_BITS = hmf_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic [7:0]             data_byte,
	input  hmf_pkg::ctl_t          ctl,
	input  logic [LENGTH_BITS-1:0] dec,
	input  logic [LENGTH_BITS-1:0] blen,
	input  logic [LENGTH_BITS-1:0] rem,
	output hmf_pkg::ctl_t          ctl_n,
	output logic [LENGTH_BITS-1:0] dec_n,
	output logic [LENGTH_BITS-1:0] blen_n,
	output logic [LENGTH_BITS-1:0] rem_n,
	output logic [2:0]             code,
	output logic                   eom
);

	localparam int L = LENGTH_BITS;
	localparam logic [L-1:0] LEN_MAX = '1;

	logic [7:0]   lc;
	logic         is_digit;
	logic         is_blank;
	logic [4:0]   hex;
	logic [L+3:0] dec_ext;
	logic [L+3:0] dec_times10;
	logic [L-1:0] dec_next10;
	logic [L-1:0] dec_next16;
	logic [L-1:0] rem_dec;
	logic [L-1:0] blen_line;
	logic         empty_line;

	assign lc = (data_byte >= "A" && data_byte <= "Z") ? data_byte + hmf_pkg::CASE_OFFSET
		: data_byte;
	assign is_digit = data_byte >= "0" && data_byte <= "9";
	assign is_blank = data_byte == hmf_pkg::CHAR_SPACE || data_byte == hmf_pkg::CHAR_TAB
		|| data_byte == hmf_pkg::CHAR_CR || data_byte == hmf_pkg::CHAR_VT
		|| data_byte == hmf_pkg::CHAR_FF;
	assign hex = hmf_pkg::hex_digit(data_byte);

	assign dec_ext     = {4'd0, dec};
	assign dec_times10 = (dec_ext << 3) + (dec_ext << 1) + {{L{1'b0}}, data_byte[3:0]};
	assign dec_next10  = (|dec_times10[L+3:L]) ? LEN_MAX : dec_times10[L-1:0];
	assign dec_next16  = (|dec[L-1:L-4]) ? LEN_MAX : {dec[L-5:0], hex[3:0]};
	assign rem_dec     = rem - {{(L-1){1'b0}}, 1'b1};

	assign empty_line = ctl.phase == hmf_pkg::PH_NAME
		&& (ctl.col == 5'd0 || (ctl.col == 5'd1 && ctl.saw_cr));

	always_comb begin
		unique case (ctl.phase)
			hmf_pkg::PH_BLANKS: blen_line = '0;
			hmf_pkg::PH_DIGITS: blen_line = dec;
			default:            blen_line = blen;
		endcase
	end

	always_comb begin
		ctl_n  = ctl;
		dec_n  = dec;
		blen_n = blen;
		rem_n  = rem;
		eom    = 1'b0;
		code   = hmf_pkg::mode_code(ctl.mode);

		unique case (ctl.mode)
			hmf_pkg::MODE_BODY: begin
				rem_n = rem_dec;
				if (rem_dec == '0) begin
					ctl_n  = hmf_pkg::CTL_RESET;
					dec_n  = '0;
					blen_n = '0;
					eom    = 1'b1;
				end
			end
			hmf_pkg::MODE_SIZE: begin
				if (data_byte == hmf_pkg::CHAR_LF) begin
					if (dec == '0) begin
						ctl_n  = hmf_pkg::CTL_RESET;
						blen_n = '0;
						rem_n  = '0;
						eom    = 1'b1;
					end else begin
						rem_n      = dec;
						ctl_n.mode = hmf_pkg::MODE_DATA;
					end
				end else if (ctl.phase == hmf_pkg::PH_NAME) begin
					if (!hex[4]) begin
						ctl_n.phase = hmf_pkg::PH_REST;
					end else begin
						dec_n = dec_next16;
					end
				end
			end
			hmf_pkg::MODE_DATA: begin
				rem_n = rem_dec;
				if (rem_dec == '0) begin
					ctl_n.mode = hmf_pkg::MODE_CRLF;
				end
			end
			hmf_pkg::MODE_CRLF: begin
				if (data_byte == hmf_pkg::CHAR_LF) begin
					ctl_n.mode  = hmf_pkg::MODE_SIZE;
					ctl_n.phase = hmf_pkg::PH_NAME;
					dec_n       = '0;
				end
			end
			default: begin
				code       = hmf_pkg::CODE_HEADER;
				ctl_n.mode = hmf_pkg::MODE_HEADER;
				if (data_byte == hmf_pkg::CHAR_LF) begin
					blen_n          = blen_line;
					ctl_n.col       = 5'd0;
					ctl_n.saw_cr    = 1'b0;
					ctl_n.len_match = 1'b1;
					ctl_n.enc_match = 1'b1;
					ctl_n.phase     = hmf_pkg::PH_NAME;
					if (empty_line) begin
						if (blen_line != '0) begin
							ctl_n.mode = hmf_pkg::MODE_BODY;
							rem_n      = blen_line;
						end else if (ctl.chunked) begin
							ctl_n.mode = hmf_pkg::MODE_SIZE;
							dec_n      = '0;
						end else begin
							ctl_n  = hmf_pkg::CTL_RESET;
							dec_n  = '0;
							blen_n = '0;
							rem_n  = '0;
							eom    = 1'b1;
						end
					end
				end else begin
					ctl_n.saw_cr = data_byte == hmf_pkg::CHAR_CR;
					unique case (ctl.phase)
						hmf_pkg::PH_NAME: begin
							if (data_byte == hmf_pkg::CHAR_COLON) begin
								if (ctl.len_match && ctl.col == hmf_pkg::CL_LEN) begin
									dec_n       = '0;
									ctl_n.phase = hmf_pkg::PH_BLANKS;
								end else begin
									if (ctl.enc_match && ctl.col == hmf_pkg::TE_LEN) begin
										ctl_n.chunked = 1'b1;
									end
									ctl_n.phase = hmf_pkg::PH_REST;
								end
							end else begin
								if (ctl.col >= hmf_pkg::CL_LEN || lc != hmf_pkg::cl_char(ctl.col)) begin
									ctl_n.len_match = 1'b0;
								end
								if (ctl.col >= hmf_pkg::TE_LEN || lc != hmf_pkg::te_char(ctl.col)) begin
									ctl_n.enc_match = 1'b0;
								end
								if (ctl.col < hmf_pkg::COL_MAX) begin
									ctl_n.col = ctl.col + 5'd1;
								end
							end
						end
						hmf_pkg::PH_BLANKS: begin
							if (is_digit) begin
								dec_n       = {{(L-4){1'b0}}, data_byte[3:0]};
								ctl_n.phase = hmf_pkg::PH_DIGITS;
							end else if (!is_blank) begin
								blen_n      = '0;
								ctl_n.phase = hmf_pkg::PH_REST;
							end
						end
						hmf_pkg::PH_DIGITS: begin
							if (is_digit) begin
								dec_n = dec_next10;
							end else begin
								blen_n      = dec;
								ctl_n.phase = hmf_pkg::PH_REST;
							end
						end
						default: begin
						end
					endcase
				end
			end
		endcase
	end

endmodule

FILE: hdl/http_message_framer.sv
// ----------------------------------------------------------------------------
// HTTP message framer
// Tags each byte of an HTTP/1.1 message with its part and marks the last byte.
// ----------------------------------------------------------------------------
//
// Channel  Signals                                          Direction
// data     data_valid, data_ready, data_byte                into the block
// result   result_valid, result_ready, out_byte,
//          part_code, end_of_message                        out of the block
//
// One byte is accepted per cycle while the result side is not stalled, and its result appears in the next cycle.
// The framing state is updated by one pass of logic from the state registers
// and the accepted byte into the state and result registers.
// A byte is accepted whenever the result register is empty or is taken in the
// same cycle, so a stall on the result side holds back only the next byte.
// Reset returns the framer to the start of a header line.
module http_message_framer #(
	parameter int LENGTH_BITS = hmf_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_ready,
	input  logic [7:0] data_byte,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] out_byte,
	output logic [2:0] part_code,
	output logic       end_of_message
);

	hmf_pkg::ctl_t          ctl_q;
	hmf_pkg::ctl_t          ctl_n;
	logic [LENGTH_BITS-1:0] dec_q;
	logic [LENGTH_BITS-1:0] dec_n;
	logic [LENGTH_BITS-1:0] blen_q;
	logic [LENGTH_BITS-1:0] blen_n;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [LENGTH_BITS-1:0] rem_n;
	logic [2:0]             code;
	logic                   eom;
	logic                   accept;

	assign data_ready = !result_valid || result_ready;
	assign accept     = data_valid && data_ready;

	hmf_step #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_step (
		.data_byte(data_byte),
		.ctl(ctl_q),
		.dec(dec_q),
		.blen(blen_q),
		.rem(rem_q),
		.ctl_n(ctl_n),
		.dec_n(dec_n),
		.blen_n(blen_n),
		.rem_n(rem_n),
		.code(code),
		.eom(eom)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q        <= hmf_pkg::CTL_RESET;
			dec_q        <= '0;
			blen_q       <= '0;
			rem_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			if (accept) begin
				ctl_q  <= ctl_n;
				dec_q  <= dec_n;
				blen_q <= blen_n;
				rem_q  <= rem_n;
			end
			if (data_ready) begin
				result_valid <= data_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_byte       <= data_byte;
			part_code      <= code;
			end_of_message <= eom;
		end
	end

	// A message can only end in the header, a fixed body or a size line.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && end_of_message |-> part_code == hmf_pkg::CODE_HEADER
		|| part_code == hmf_pkg::CODE_BODY || part_code == hmf_pkg::CODE_SIZE)
		else $error("message ended in an unexpected part");

	// The transaction after a final byte starts from the reset state.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && eom |=> ctl_q == hmf_pkg::CTL_RESET && blen_q == '0)
		else $error("framer state not cleared after end of message");

	// Counted parts always have bytes left to receive.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.mode == hmf_pkg::MODE_BODY || ctl_q.mode == hmf_pkg::MODE_DATA
		|-> rem_q != '0)
		else $error("counted part entered with no bytes remaining");

	// An empty result register never holds back the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> data_ready)
		else $error("input stalled with empty result register");

endmodule
